/* rtl/sha256bh_pkg.sv */
// sha256bh_pkg: types, constant tables and sigma functions for the sha-256 block hasher
// used by sha256_block_hasher_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sha256bh_pkg;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    typedef logic [31:0] t_word;

    localparam t_word IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word f_bsig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word f_bsig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word f_ssig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word f_ssig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

/* rtl/sha256_block_hasher_top.sv */
// sha256_block_hasher_top: sha-256 compression core with one shared round unit
// depends on sha256bh_pkg
//
// usage: feed the padded message as 32-bit big-endian words on the request channel
// (i_valid / o_stall), sixteen per 512-bit block. i_first_block is sampled on word 0
// of a block and reloads the initial hash; i_final_block is sampled on word 15 and
// makes the block emit its digest.
// words 0 to 14 are taken one per cycle. after word 15 the block raises o_stall and
// runs the 64 rounds on its single round unit, one round per cycle, then adds the
// working variables into the hash in ST_ADD; no word of the next block is taken
// until it is back in ST_LOAD.
// after a final block the eight digest words leave on the result channel
// (o_valid / i_stall) through one output register, index 0 first, the eighth flagged
// with o_digest_last; the block stays busy until the eighth word is in the register,
// and this takes longer while i_stall is high.
// a pending result does not block new input words once emission is done.
// reset (synchronous, active low) loads the initial hash, clears the word and round
// counters and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module sha256_block_hasher_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  [31:0]          i_message_word,
    input  wire                  i_first_block,
    input  wire                  i_final_block,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [31:0]          o_digest_word,
    output logic [2:0]           o_digest_index,
    output logic                 o_digest_last
);
    import sha256bh_pkg::*;

    t_state      r_state, n_state;
    t_word       r_hash [8];
    t_word       n_hash [8];
    t_word       r_v [8];
    t_word       n_v [8];
    t_word       r_win [16];
    t_word       n_win [16];
    logic [3:0]  r_word_cnt, n_word_cnt;
    logic [5:0]  r_round, n_round;
    logic        r_final, n_final;
    logic [2:0]  r_emit_idx, n_emit_idx;
    logic        r_out_valid, n_out_valid;
    t_word       r_out_word, n_out_word;
    logic [2:0]  r_out_idx, n_out_idx;

    logic        in_acc;
    logic        out_load;
    t_word       w_new;
    t_word       t1;
    t_word       t2;

    assign o_stall = (r_state != ST_LOAD);
    assign in_acc  = i_valid && !o_stall;

    // round unit and schedule extension
    always_comb begin
        w_new = r_win[0] + f_ssig0(r_win[1]) + r_win[9] + f_ssig1(r_win[14]);
        t1 = r_v[7] + f_bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + K_TABLE[r_round] + r_win[0];
        t2 = f_bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_v         = r_v;
        n_win       = r_win;
        n_word_cnt  = r_word_cnt;
        n_round     = r_round;
        n_final     = r_final;
        n_emit_idx  = r_emit_idx;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_valid = r_out_valid;
        out_load    = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_word_cnt == 4'd0 && i_first_block) begin
                        n_hash = IV_TABLE;
                    end
                    for (int i = 0; i < 15; i++) begin
                        n_win[i] = r_win[i+1];
                    end
                    n_win[15]  = i_message_word;
                    n_word_cnt = r_word_cnt + 4'd1;
                    if (r_word_cnt == 4'd15) begin
                        n_v     = r_hash;
                        n_final = i_final_block;
                        n_round = 6'd0;
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[15] = w_new;
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_hash[i] = r_hash[i] + r_v[i];
                end
                n_emit_idx = 3'd0;
                n_state    = r_final ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_word  = r_hash[r_emit_idx];
                    n_out_idx   = r_emit_idx;
                    n_emit_idx  = r_emit_idx + 3'd1;
                    if (r_emit_idx == 3'd7) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_hash      <= IV_TABLE;
            r_v         <= '{default: 32'h0};
            r_word_cnt  <= 4'd0;
            r_round     <= 6'd0;
            r_final     <= 1'b0;
            r_emit_idx  <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_v         <= n_v;
            r_word_cnt  <= n_word_cnt;
            r_round     <= n_round;
            r_final     <= n_final;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // schedule window and output payload need no reset
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (out_load) begin
            r_out_word <= n_out_word;
            r_out_idx  <= n_out_idx;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_digest_word  = r_out_word;
    assign o_digest_index = r_out_idx;
    assign o_digest_last  = (r_out_idx == 3'd7);

    a_busy_after_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_word_cnt == 4'd15) |=> (o_stall && r_state == ST_ROUND && r_round == 6'd0))
        else $error("round unit did not start after sixteenth word");

    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_round == 6'd0))
        else $error("round counter not cleared between blocks");

    a_emit_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && r_final) |=> (r_state == ST_EMIT && r_emit_idx == 3'd0))
        else $error("digest emission did not start at word zero");

    a_no_input_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_emit_idx == 3'd0) |-> (r_word_cnt == 4'd0))
        else $error("digest emitted with a partial block pending");

endmodule

`default_nettype wire
